// ===== rtl/scq_pkg.sv =====
// ---------------------------------------------------------------------------
// Speed command quantizer package
// Widths, register reset values, register index codes and the item types
// shared by the front end, the divider cells and the top level.
// ---------------------------------------------------------------------------
package scq_pkg;

   // field widths
   localparam int CMD_W    = 17;   // command, 0.01 kt or 0.0001 Mach
   localparam int STEP_W   = 14;   // quantization step
   localparam int DIST_W   = 21;   // signed distance to go
   localparam int CDIST_W  = 20;   // transition distance registers
   localparam int MSTEP_W  = 11;   // Mach step register
   localparam int FRAC_W   = 9;    // hysteresis fraction, Q8
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   // divider: numerator 2v+s, denominator 2s
   localparam int NUM_W    = CMD_W + 2;
   localparam int DEN_W    = STEP_W + 1;
   localparam int QPROD_W  = NUM_W + STEP_W;
   localparam int HPROD_W  = STEP_W + FRAC_W;
   localparam int HDIFF_W  = CMD_W + 8;

   localparam logic [CMD_W-1:0] CMD_MAX = 17'd100000;

   // register reset values
   localparam logic [CDIST_W-1:0] FINAL_DIST_RST  = 20'd18520;
   localparam logic [CDIST_W-1:0] MIDDLE_DIST_RST = 20'd37040;
   localparam logic [STEP_W-1:0]  FINAL_STEP_RST  = 14'd100;
   localparam logic [STEP_W-1:0]  MIDDLE_STEP_RST = 14'd500;
   localparam logic [STEP_W-1:0]  FIRST_STEP_RST  = 14'd1000;
   localparam logic [MSTEP_W-1:0] MACH_STEP_RST   = 11'd200;
   localparam logic [FRAC_W-1:0]  HYST_FRAC_RST   = 9'd192;

   // command kinds
   localparam logic OP_AIRSPEED = 1'b0;
   localparam logic OP_MACH     = 1'b1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FINAL_DIST  = 3'd0,
      CSR_MIDDLE_DIST = 3'd1,
      CSR_FINAL_STEP  = 3'd2,
      CSR_MIDDLE_STEP = 3'd3,
      CSR_FIRST_STEP  = 3'd4,
      CSR_MACH_STEP   = 3'd5,
      CSR_HYST_FRAC   = 3'd6
   } scq_csr_type;

   // configuration seen by the front end
   typedef struct packed {
      logic [CDIST_W-1:0] final_dist;
      logic [CDIST_W-1:0] middle_dist;
      logic [STEP_W-1:0]  final_step;
      logic [STEP_W-1:0]  middle_step;
      logic [STEP_W-1:0]  first_step;
      logic [MSTEP_W-1:0] mach_step;
      logic [FRAC_W-1:0]  hyst_frac;
   } scq_cfg_type;

   // one item as it travels along the divider chain
   typedef struct packed {
      logic [DEN_W-1:0]  rem;    // partial remainder
      logic [NUM_W-1:0]  num;    // numerator bits still to shift in, msb first
      logic [NUM_W-1:0]  quo;    // quotient bits so far
      logic [DEN_W-1:0]  den;    // 2 * step
      logic [STEP_W-1:0] step;
      logic [CMD_W-1:0]  val;    // held or new command before rounding
   } scq_stage_type;

endpackage

// ===== rtl/scq_front.sv =====
// ---------------------------------------------------------------------------
// Speed command quantizer front end
// Picks the step, applies the hysteresis hold and forms the rounding
// numerator and denominator for the divider chain. Two register stages.
// ---------------------------------------------------------------------------
module scq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  scq_pkg::scq_cfg_type          cfg,
   input  logic                          in_valid,
   input  logic                          in_op,
   input  logic [scq_pkg::DIST_W-1:0]    in_dist,
   input  logic [scq_pkg::CMD_W-1:0]     in_new,
   input  logic [scq_pkg::CMD_W-1:0]     in_prev,
   output logic                          out_valid,
   output scq_pkg::scq_stage_type        out_data
);
   import scq_pkg::*;

   logic [CDIST_W-1:0] dist_m;
   logic [STEP_W-1:0]  step_sel;
   logic [CMD_W-1:0]   diff;

   logic               s1_valid_ff;
   logic [STEP_W-1:0]  s1_step_ff,  s1_step_in;
   logic [CMD_W-1:0]   s1_diff_ff,  s1_diff_in;
   logic [HPROD_W-1:0] s1_band_ff,  s1_band_in;
   logic [CMD_W-1:0]   s1_new_ff;
   logic [CMD_W-1:0]   s1_prev_ff;

   logic               s2_valid_ff;
   scq_stage_type      s2_data_ff, s2_data_in;
   logic               hold;
   logic [CMD_W-1:0]   held;

   // step selection: negative distance counts as zero
   always_comb begin
      dist_m = in_dist[DIST_W-1] ? '0 : in_dist[CDIST_W-1:0];
      priority if (in_op == OP_MACH) begin
         step_sel = {{(STEP_W-MSTEP_W){1'b0}}, cfg.mach_step};
      end else if (dist_m < cfg.final_dist) begin
         step_sel = cfg.final_step;
      end else if (dist_m < cfg.middle_dist) begin
         step_sel = cfg.middle_step;
      end else begin
         step_sel = cfg.first_step;
      end
      diff = (in_new > in_prev) ? (in_new - in_prev) : (in_prev - in_new);
      s1_step_in = step_sel;
      s1_diff_in = diff;
      s1_band_in = HPROD_W'(step_sel) * HPROD_W'(cfg.hyst_frac);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_step_ff <= s1_step_in;
         s1_diff_ff <= s1_diff_in;
         s1_band_ff <= s1_band_in;
         s1_new_ff  <= in_new;
         s1_prev_ff <= in_prev;
      end
   end

   // hysteresis hold: |new - prev| * 256 < step * fraction
   always_comb begin
      hold = {s1_diff_ff, 8'd0} < HDIFF_W'(s1_band_ff);
      held = hold ? s1_prev_ff : s1_new_ff;
      s2_data_in.rem  = '0;
      s2_data_in.num  = {1'b0, held, 1'b0} + NUM_W'(s1_step_ff);
      s2_data_in.quo  = '0;
      s2_data_in.den  = {s1_step_ff, 1'b0};
      s2_data_in.step = s1_step_ff;
      s2_data_in.val  = held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== rtl/scq_cell.sv =====
// ---------------------------------------------------------------------------
// Speed command quantizer divider cell
// One restoring division step: shifts in the next numerator bit, subtracts
// the denominator where it fits and appends one quotient bit.
// ---------------------------------------------------------------------------
module scq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  scq_pkg::scq_stage_type in_data,
   output logic                   out_valid,
   output scq_pkg::scq_stage_type out_data
);
   import scq_pkg::*;

   logic [DEN_W:0]  rem_sh;
   logic [DEN_W:0]  rem_sub;
   logic            fits;
   logic            valid_ff;
   scq_stage_type   data_ff, data_in;

   // one quotient bit
   always_comb begin
      rem_sh  = {in_data.rem, in_data.num[NUM_W-1]};
      fits    = rem_sh >= {1'b0, in_data.den};
      rem_sub = rem_sh - {1'b0, in_data.den};
      data_in      = in_data;
      data_in.rem  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      data_in.num  = {in_data.num[NUM_W-2:0], 1'b0};
      data_in.quo  = {in_data.quo[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/speed_command_quantizer_unit.sv =====
// ---------------------------------------------------------------------------
// Speed command quantizer
// Quantizes airspeed or Mach commands to a distance dependent step with a
// hysteresis hold and round-half-up, through a chain of divider cells.
// ---------------------------------------------------------------------------
// Pipeline: 23 register stages (2 front stages, 19 divider cells, 1 multiply
//   stage, 1 output register).
// Throughput: one item per cycle; the whole pipeline advances together and
//   freezes while a result waits on rsp_tready.
// Reset: clears all valid flags and loads the register reset values.
module speed_command_quantizer_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata,
   // command items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // distance_to_go[20:0], new_command[37:21],
                                   // previous_command[54:38], zero pad [55]
   input  logic        req_tuser,  // op: 0 airspeed, 1 Mach
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // quantized_command[16:0], step_used[30:17],
                                   // zero pad [31]
);
   import scq_pkg::*;

   scq_cfg_type   cfg_ff, cfg_in;
   logic          en;

   logic          chain_valid [NUM_W+1];
   scq_stage_type chain_data  [NUM_W+1];

   logic               mul_valid_ff;
   logic [QPROD_W-1:0] mul_prod_ff, mul_prod_in;
   logic [STEP_W-1:0]  mul_step_ff;
   logic [CMD_W-1:0]   mul_val_ff;

   logic               out_valid_ff;
   logic [CMD_W-1:0]   out_cmd_ff, out_cmd_in;
   logic [STEP_W-1:0]  out_step_ff;
   logic [QPROD_W-1:0] rounded;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FINAL_DIST:  cfg_in.final_dist  = csr_wdata[CDIST_W-1:0];
            CSR_MIDDLE_DIST: cfg_in.middle_dist = csr_wdata[CDIST_W-1:0];
            CSR_FINAL_STEP:  cfg_in.final_step  = csr_wdata[STEP_W-1:0];
            CSR_MIDDLE_STEP: cfg_in.middle_step = csr_wdata[STEP_W-1:0];
            CSR_FIRST_STEP:  cfg_in.first_step  = csr_wdata[STEP_W-1:0];
            CSR_MACH_STEP:   cfg_in.mach_step   = csr_wdata[MSTEP_W-1:0];
            CSR_HYST_FRAC:   cfg_in.hyst_frac   = csr_wdata[FRAC_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.final_dist  <= FINAL_DIST_RST;
         cfg_ff.middle_dist <= MIDDLE_DIST_RST;
         cfg_ff.final_step  <= FINAL_STEP_RST;
         cfg_ff.middle_step <= MIDDLE_STEP_RST;
         cfg_ff.first_step  <= FIRST_STEP_RST;
         cfg_ff.mach_step   <= MACH_STEP_RST;
         cfg_ff.hyst_frac   <= HYST_FRAC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline advances unless a result is held back
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   scq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_op     (req_tuser),
      .in_dist   (req_tdata[DIST_W-1:0]),
      .in_new    (req_tdata[DIST_W+CMD_W-1:DIST_W]),
      .in_prev   (req_tdata[DIST_W+2*CMD_W-1:DIST_W+CMD_W]),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      scq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // quotient times step
   assign mul_prod_in = QPROD_W'(chain_data[NUM_W].quo) * QPROD_W'(chain_data[NUM_W].step);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= chain_valid[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_prod_ff <= mul_prod_in;
         mul_step_ff <= chain_data[NUM_W].step;
         mul_val_ff  <= chain_data[NUM_W].val;
      end
   end

   // zero step passes the value through; saturate at the range top
   always_comb begin
      rounded    = (mul_step_ff == '0) ? QPROD_W'(mul_val_ff) : mul_prod_ff;
      out_cmd_in = (rounded > QPROD_W'(CMD_MAX)) ? CMD_MAX : rounded[CMD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_cmd_ff  <= out_cmd_in;
         out_step_ff <= mul_step_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_step_ff, out_cmd_ff};

   // result never leaves the command range
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_cmd_ff <= CMD_MAX)
      else $error("quantized command above range");

   // divider remainder stays below the denominator
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (chain_valid[NUM_W] && chain_data[NUM_W].den != '0)
         |-> chain_data[NUM_W].rem < chain_data[NUM_W].den)
      else $error("divider remainder out of bound");

   // multiply and output stages are empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff && !mul_valid_ff)
      else $error("valid after reset");

   // an item at the chain end reaches the multiply stage when advancing
   a_chain_advance: assert property (@(posedge clock) disable iff (reset)
      (en && chain_valid[NUM_W]) |=> mul_valid_ff)
      else $error("item lost between divider and multiplier");

endmodule
